[src/comfort_indicator_sequencer_defines.svh]
// Assertion macros shared by the comfort indicator sequencer RTL.
// Expects signals named clock and reset in the including module.
`ifndef COMFORT_INDICATOR_SEQUENCER_DEFINES_SVH
`define COMFORT_INDICATOR_SEQUENCER_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define CIS_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Same-cycle implication.
`define CIS_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CIS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/cis_pkg.sv]
// Shared types, codes and lookup tables for the comfort indicator sequencer.
// No dependencies; imported by every module of the block.
package cis_pkg;

   localparam int PERIOD_W   = 16;
   localparam int MULT_W     = 8;
   localparam int BLINK_W    = 4;
   localparam int LEVEL_W    = 3;
   localparam int COLOR_W    = 2;
   localparam int PHASE_W    = 3;
   localparam int TEMP_W     = 8;
   localparam int HUM_W      = 7;
   localparam int KIND_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic signed [TEMP_W-1:0] temperature;
      logic [HUM_W-1:0]         humidity;
   } cis_req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] led_color;
      logic               measure_request;
      logic [LEVEL_W-1:0] comfort_class;
      logic               monitoring_on;
      logic [PHASE_W-1:0] phase_now;
   } cis_rsp_type;

   typedef struct packed {
      logic [MULT_W-1:0]   event_multiplier;
      logic [BLINK_W-1:0]  blink_limit;
      logic [PERIOD_W-1:0] long_period;
      logic [PERIOD_W-1:0] blink_on_period;
      logic [PERIOD_W-1:0] blink_off_period;
      logic [PERIOD_W-1:0] short_period;
      logic [PERIOD_W-1:0] restart_period;
      logic [HUM_W-1:0]    dry_threshold;
   } cis_cfg_type;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BUTTON  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MEASURE = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_EVENT_MULT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BLINK_LIMIT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LONG        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BLINK_ON    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BLINK_OFF   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SHORT       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RESTART     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_DRY_THRESH  = 3'd7;

   localparam cis_cfg_type CFG_RESET = '{
      event_multiplier: 8'd20,
      blink_limit:      4'd5,
      long_period:      16'd65535,
      blink_on_period:  16'd100,
      blink_off_period: 16'd13007,
      short_period:     16'd10,
      restart_period:   16'd1,
      dry_threshold:    7'd50
   };

   // comfort levels
   localparam logic [LEVEL_W-1:0] LV_DRY       = 3'd0;
   localparam logic [LEVEL_W-1:0] LV_WET       = 3'd1;
   localparam logic [LEVEL_W-1:0] LV_COMFORT   = 3'd2;
   localparam logic [LEVEL_W-1:0] LV_STILL_WET = 3'd3;
   localparam logic [LEVEL_W-1:0] LV_STILL_DRY = 3'd4;

   // LED colors
   localparam logic [COLOR_W-1:0] COL_OFF   = 2'd0;
   localparam logic [COLOR_W-1:0] COL_RED   = 2'd1;
   localparam logic [COLOR_W-1:0] COL_GREEN = 2'd2;
   localparam logic [COLOR_W-1:0] COL_BLUE  = 2'd3;

   typedef enum logic [4:0] {
      PH_MEASURE   = 5'b00001,
      PH_LED_ON    = 5'b00010,
      PH_BLINK_ON  = 5'b00100,
      PH_LED_OFF   = 5'b01000,
      PH_MEASURING = 5'b10000
   } cis_phase_type;

   localparam logic [PHASE_W-1:0] PHC_MEASURE   = 3'd0;
   localparam logic [PHASE_W-1:0] PHC_LED_ON    = 3'd1;
   localparam logic [PHASE_W-1:0] PHC_BLINK_ON  = 3'd2;
   localparam logic [PHASE_W-1:0] PHC_LED_OFF   = 3'd3;
   localparam logic [PHASE_W-1:0] PHC_MEASURING = 3'd4;

   function automatic logic [PHASE_W-1:0] phase_code(input cis_phase_type ph);
      logic [PHASE_W-1:0] code;
      unique case (ph)
         PH_MEASURE:   code = PHC_MEASURE;
         PH_LED_ON:    code = PHC_LED_ON;
         PH_BLINK_ON:  code = PHC_BLINK_ON;
         PH_LED_OFF:   code = PHC_LED_OFF;
         PH_MEASURING: code = PHC_MEASURING;
         default:      code = PHC_MEASURE;
      endcase
      return code;
   endfunction

   // comfort zones: temperature window and humidity bounds per degree
   localparam logic signed [TEMP_W-1:0] COMFY_T_MIN = 8'sd18;
   localparam logic signed [TEMP_W-1:0] COMFY_T_MAX = 8'sd24;
   localparam logic [HUM_W-1:0]         COMFY_H_MIN = 7'd33;
   localparam logic [HUM_W-1:0]         COMFY_H_MAX = 7'd75;
   localparam logic signed [TEMP_W-1:0] STILL_T_MIN = 8'sd16;
   localparam logic signed [TEMP_W-1:0] STILL_T_MAX = 8'sd27;
   localparam logic [HUM_W-1:0]         STILL_H_MIN = 7'd17;
   localparam logic [HUM_W-1:0]         STILL_H_MAX = 7'd87;

   function automatic logic [HUM_W-1:0] comfy_lo(input logic [2:0] idx);
      logic [HUM_W-1:0] v;
      case (idx)
         3'd0:    v = 7'd63;
         3'd1:    v = 7'd37;
         3'd2:    v = 7'd36;
         3'd3:    v = 7'd35;
         3'd4:    v = 7'd35;
         3'd5:    v = 7'd34;
         3'd6:    v = 7'd33;
         default: v = 7'd127;
      endcase
      return v;
   endfunction

   function automatic logic [HUM_W-1:0] comfy_hi(input logic [2:0] idx);
      logic [HUM_W-1:0] v;
      case (idx)
         3'd0:    v = 7'd75;
         3'd1:    v = 7'd73;
         3'd2:    v = 7'd71;
         3'd3:    v = 7'd68;
         3'd4:    v = 7'd66;
         3'd5:    v = 7'd55;
         3'd6:    v = 7'd41;
         default: v = 7'd0;
      endcase
      return v;
   endfunction

   function automatic logic [HUM_W-1:0] still_lo(input logic [3:0] idx);
      logic [HUM_W-1:0] v;
      case (idx)
         4'd0:    v = 7'd75;
         4'd1:    v = 7'd36;
         4'd2:    v = 7'd30;
         4'd3:    v = 7'd25;
         4'd4:    v = 7'd19;
         4'd5:    v = 7'd19;
         4'd6:    v = 7'd18;
         4'd7:    v = 7'd18;
         4'd8:    v = 7'd17;
         4'd9:    v = 7'd17;
         4'd10:   v = 7'd22;
         4'd11:   v = 7'd32;
         default: v = 7'd127;
      endcase
      return v;
   endfunction

   function automatic logic [HUM_W-1:0] still_hi(input logic [3:0] idx);
      logic [HUM_W-1:0] v;
      case (idx)
         4'd0:    v = 7'd75;
         4'd1:    v = 7'd87;
         4'd2:    v = 7'd85;
         4'd3:    v = 7'd83;
         4'd4:    v = 7'd82;
         4'd5:    v = 7'd81;
         4'd6:    v = 7'd76;
         4'd7:    v = 7'd71;
         4'd8:    v = 7'd66;
         4'd9:    v = 7'd63;
         4'd10:   v = 7'd50;
         4'd11:   v = 7'd32;
         default: v = 7'd0;
      endcase
      return v;
   endfunction

endpackage

[src/cis_classify.sv]
// Comfort classifier: maps temperature and humidity to a comfort level.
// Depends on cis_pkg for the zone tables and level codes.
module cis_classify (
   input  logic signed [cis_pkg::TEMP_W-1:0] temperature,
   input  logic [cis_pkg::HUM_W-1:0]         humidity,
   input  logic [cis_pkg::HUM_W-1:0]         dry_threshold,
   output logic [cis_pkg::LEVEL_W-1:0]       level
);
   import cis_pkg::*;

   logic [TEMP_W-1:0] comfy_off;
   logic [TEMP_W-1:0] still_off;
   logic              dry;
   logic              in_comfy;
   logic              in_still;

   assign comfy_off = temperature - COMFY_T_MIN;
   assign still_off = temperature - STILL_T_MIN;
   assign dry       = humidity < dry_threshold;

   always_comb begin
      in_comfy = (temperature >= COMFY_T_MIN) && (temperature <= COMFY_T_MAX)
              && (humidity >= COMFY_H_MIN) && (humidity <= COMFY_H_MAX)
              && (humidity >= comfy_lo(comfy_off[2:0]))
              && (humidity <= comfy_hi(comfy_off[2:0]));
      in_still = (temperature >= STILL_T_MIN) && (temperature <= STILL_T_MAX)
              && (humidity >= STILL_H_MIN) && (humidity <= STILL_H_MAX)
              && (humidity >= still_lo(still_off[3:0]))
              && (humidity <= still_hi(still_off[3:0]));
      if (in_comfy) begin
         level = LV_COMFORT;
      end else if (in_still) begin
         level = dry ? LV_STILL_DRY : LV_STILL_WET;
      end else begin
         level = dry ? LV_DRY : LV_WET;
      end
   end

endmodule

[src/cis_csr.sv]
// Configuration register file for the comfort indicator sequencer.
// Depends on cis_pkg for the register indexes and reset values.
module cis_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cis_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cis_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output cis_pkg::cis_cfg_type             cfg
);
   import cis_pkg::*;

   cis_cfg_type cfg_ff;
   cis_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_EVENT_MULT:  cfg_in.event_multiplier = csr_wdata[MULT_W-1:0];
            REG_BLINK_LIMIT: cfg_in.blink_limit      = csr_wdata[BLINK_W-1:0];
            REG_LONG:        cfg_in.long_period      = csr_wdata[PERIOD_W-1:0];
            REG_BLINK_ON:    cfg_in.blink_on_period  = csr_wdata[PERIOD_W-1:0];
            REG_BLINK_OFF:   cfg_in.blink_off_period = csr_wdata[PERIOD_W-1:0];
            REG_SHORT:       cfg_in.short_period     = csr_wdata[PERIOD_W-1:0];
            REG_RESTART:     cfg_in.restart_period   = csr_wdata[PERIOD_W-1:0];
            REG_DRY_THRESH:  cfg_in.dry_threshold    = csr_wdata[HUM_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[src/cis_core.sv]
// Sequencer state: monitoring flag, tick timer, event divider and phase machine.
// Depends on cis_pkg and the assertion macros in comfort_indicator_sequencer_defines.svh.
`include "comfort_indicator_sequencer_defines.svh"

module cis_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  cis_pkg::cis_req_type          item,
   input  logic [cis_pkg::LEVEL_W-1:0]   class_level,
   input  cis_pkg::cis_cfg_type          cfg,
   output cis_pkg::cis_rsp_type          rsp
);
   import cis_pkg::*;

   logic                active_ff, active_in;
   cis_phase_type       phase_ff, phase_in;
   logic [MULT_W-1:0]   event_ff, event_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [PERIOD_W-1:0] tick_ff, tick_in;
   logic [BLINK_W-1:0]  blinks_ff, blinks_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic [COLOR_W-1:0]  color_ff, color_in;
   logic                meas_req;
   logic                step;
   logic [MULT_W:0]     event_next;

   assign event_next = {1'b0, event_ff} + {{MULT_W{1'b0}}, 1'b1};

   always_comb begin
      active_in = active_ff;
      phase_in  = phase_ff;
      event_in  = event_ff;
      period_in = period_ff;
      tick_in   = tick_ff;
      blinks_in = blinks_ff;
      level_in  = level_ff;
      color_in  = color_ff;
      meas_req  = 1'b0;
      step      = 1'b0;

      unique case (item.kind)
         KIND_TICK: begin
            if (period_ff != '0) begin
               if (tick_ff >= period_ff) begin
                  tick_in = '0;
                  if (event_next < {1'b0, cfg.event_multiplier}) begin
                     event_in = event_next[MULT_W-1:0];
                  end else begin
                     event_in = '0;
                     step     = 1'b1;
                  end
               end else begin
                  tick_in = tick_ff + 1'b1;
               end
            end
         end
         KIND_BUTTON: begin
            active_in = ~active_ff;
            tick_in   = '0;
            if (!active_ff) begin
               period_in = cfg.short_period;
            end else begin
               period_in = '0;
               phase_in  = PH_MEASURE;
               color_in  = COL_OFF;
            end
         end
         KIND_MEASURE: begin
            level_in = class_level;
            phase_in = PH_LED_OFF;
         end
         default: ;
      endcase

      // phase step; every period load also restarts the tick count
      if (step) begin
         unique case (phase_ff)
            PH_MEASURE: begin
               period_in = cfg.short_period;
               phase_in  = PH_MEASURING;
               meas_req  = 1'b1;
            end
            PH_MEASURING: begin
               period_in = cfg.short_period;
            end
            PH_LED_OFF: begin
               if (blinks_ff >= cfg.blink_limit) begin
                  phase_in  = PH_MEASURE;
                  period_in = cfg.short_period;
                  blinks_in = '0;
               end else begin
                  case (level_ff) inside
                     LV_DRY, LV_WET: begin
                        color_in  = (level_ff == LV_WET) ? COL_BLUE : COL_RED;
                        phase_in  = PH_LED_ON;
                        period_in = cfg.long_period;
                     end
                     LV_STILL_WET, LV_STILL_DRY, LV_COMFORT: begin
                        if (level_ff == LV_STILL_WET) begin
                           color_in = COL_BLUE;
                        end else if (level_ff == LV_STILL_DRY) begin
                           color_in = COL_RED;
                        end else begin
                           color_in = COL_GREEN;
                        end
                        phase_in  = PH_BLINK_ON;
                        blinks_in = blinks_ff + 1'b1;
                        period_in = cfg.blink_on_period;
                     end
                     default: ;
                  endcase
               end
            end
            PH_BLINK_ON: begin
               period_in = cfg.blink_off_period;
               phase_in  = PH_LED_OFF;
               color_in  = COL_OFF;
            end
            PH_LED_ON: begin
               phase_in  = PH_MEASURE;
               period_in = cfg.restart_period;
               color_in  = COL_OFF;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp.led_color       = color_in;
      rsp.measure_request = meas_req;
      rsp.comfort_class   = level_in;
      rsp.monitoring_on   = active_in;
      rsp.phase_now       = phase_code(phase_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         phase_ff  <= PH_MEASURE;
         event_ff  <= '0;
         period_ff <= '0;
         tick_ff   <= '0;
         blinks_ff <= '0;
         level_ff  <= LV_DRY;
         color_ff  <= COL_OFF;
      end else if (fire) begin
         active_ff <= active_in;
         phase_ff  <= phase_in;
         event_ff  <= event_in;
         period_ff <= period_in;
         tick_ff   <= tick_in;
         blinks_ff <= blinks_in;
         level_ff  <= level_in;
         color_ff  <= color_in;
      end
   end

   `CIS_ASSERT_HOLDS(a_off_timer_stopped, active_ff || (period_ff == '0), "timer runs while off")
   `CIS_ASSERT_HOLDS(a_tick_bounded, tick_ff <= period_ff, "tick count beyond period")
   `CIS_ASSERT_IMPLIES(a_led_on_color, phase_ff == PH_LED_ON, (color_ff == COL_RED) || (color_ff == COL_BLUE), "steady LED without color")
   `CIS_ASSERT_IMPLIES(a_req_measuring, meas_req, (phase_in == PH_MEASURING) && step, "measurement request outside measure step")
   `CIS_ASSERT_NEXT(a_switch_on, fire && (item.kind == KIND_BUTTON) && !active_ff, active_ff && (tick_ff == '0) && (period_ff == $past(cfg.short_period)), "switch-on did not load short period")

endmodule

[src/comfort_indicator_sequencer.sv]
// Comfort indicator sequencer top level: request register, classifier, state core, result register.
// An accepted request waits in the request register; its result is captured in the result register.
// Throughput: one request per cycle without stalls; cis_core updates state per accepted request.
// The result register is released by rsp_ready; a stalled result holds the request register.
// Reset (synchronous, active high): monitoring off, timer stopped, phase measure, LED off,
// configuration registers back to their defaults, both pipeline registers empty.
module comfort_indicator_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  cis_pkg::cis_req_type            req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output cis_pkg::cis_rsp_type            rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cis_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cis_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import cis_pkg::*;

   logic               in_valid_ff;
   cis_req_type        in_data_ff;
   logic               out_valid_ff;
   cis_rsp_type        out_data_ff;
   logic               advance;
   cis_cfg_type        cfg;
   logic [LEVEL_W-1:0] class_level;
   cis_rsp_type        core_rsp;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   cis_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cis_classify u_classify (
      .temperature   (in_data_ff.temperature),
      .humidity      (in_data_ff.humidity),
      .dry_threshold (cfg.dry_threshold),
      .level         (class_level)
   );

   cis_core u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (advance),
      .item        (in_data_ff),
      .class_level (class_level),
      .cfg         (cfg),
      .rsp         (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= core_rsp;
      end
   end

endmodule

[bench/tb_top.sv]
// Self-checking bench for comfort_indicator_sequencer: directed and random requests,
// a per-request status predictor, and response checks under random backpressure.
// Depends on cis_pkg (payload types, codes, register indexes) and the block's RTL.
module tb_top;
   import cis_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   cis_req_type           req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   cis_rsp_type           rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   comfort_indicator_sequencer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // comfort zone humidity bounds, indexed by degrees above the zone's lowest temperature
   int ideal_lo [0:6]  = '{63, 37, 36, 35, 35, 34, 33};
   int ideal_hi [0:6]  = '{75, 73, 71, 68, 66, 55, 41};
   int fair_lo  [0:11] = '{75, 36, 30, 25, 19, 19, 18, 18, 17, 17, 22, 32};
   int fair_hi  [0:11] = '{75, 87, 85, 83, 82, 81, 76, 71, 66, 63, 50, 32};

   // shadow configuration and sequencer state
   cis_cfg_type          shadow_cfg = CFG_RESET;
   logic                 mon_on = 1'b0;
   logic [PHASE_W-1:0]   phase_cur = PHC_MEASURE;
   logic [MULT_W-1:0]    evt_count = '0;
   logic [PERIOD_W-1:0]  tmr_period = '0;
   logic [PERIOD_W-1:0]  tmr_ticks = '0;
   logic [BLINK_W-1:0]   blinks_shown = '0;
   logic [LEVEL_W-1:0]   level_cur = LV_DRY;
   logic [COLOR_W-1:0]   led_col = COL_OFF;

   cis_req_type req_backlog [$];
   cis_rsp_type status_expect [$];
   int          mismatches = 0;
   int          reqs_taken = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          stall_left = 0;
   logic        stall_done = 1'b0;
   logic        gen_on = 1'b0;

   function automatic void load_timer(input logic [PERIOD_W-1:0] p);
      tmr_period = p;
      tmr_ticks = '0;
   endfunction

   function automatic logic [LEVEL_W-1:0] classify_climate(input int t, input int h);
      logic dry;
      int   i;
      dry = h < int'(shadow_cfg.dry_threshold);
      if (t >= 18 && t <= 24 && h >= 33 && h <= 75) begin
         i = t - 18;
         if (h >= ideal_lo[i] && h <= ideal_hi[i]) return LV_COMFORT;
      end
      if (t >= 16 && t <= 27 && h >= 17 && h <= 87) begin
         i = t - 16;
         if (h >= fair_lo[i] && h <= fair_hi[i]) return dry ? LV_STILL_DRY : LV_STILL_WET;
      end
      return dry ? LV_DRY : LV_WET;
   endfunction

   function automatic void start_flash(input logic [COLOR_W-1:0] c);
      led_col = c;
      phase_cur = PHC_BLINK_ON;
      blinks_shown = blinks_shown + 1'b1;
      load_timer(shadow_cfg.blink_on_period);
   endfunction

   // one step of the phase machine; returns the measurement strobe
   function automatic logic step_phase();
      logic meas;
      meas = 1'b0;
      case (phase_cur)
         PHC_MEASURE: begin
            load_timer(shadow_cfg.short_period);
            phase_cur = PHC_MEASURING;
            meas = 1'b1;
         end
         PHC_MEASURING: load_timer(shadow_cfg.short_period);
         PHC_LED_OFF: begin
            if (blinks_shown >= shadow_cfg.blink_limit) begin
               phase_cur = PHC_MEASURE;
               load_timer(shadow_cfg.short_period);
               blinks_shown = '0;
            end else if (level_cur == LV_WET || level_cur == LV_DRY) begin
               led_col = (level_cur == LV_WET) ? COL_BLUE : COL_RED;
               phase_cur = PHC_LED_ON;
               load_timer(shadow_cfg.long_period);
            end else if (level_cur == LV_STILL_WET) begin
               start_flash(COL_BLUE);
            end else if (level_cur == LV_STILL_DRY) begin
               start_flash(COL_RED);
            end else if (level_cur == LV_COMFORT) begin
               start_flash(COL_GREEN);
            end
         end
         PHC_BLINK_ON: begin
            load_timer(shadow_cfg.blink_off_period);
            phase_cur = PHC_LED_OFF;
            led_col = COL_OFF;
         end
         PHC_LED_ON: begin
            phase_cur = PHC_MEASURE;
            load_timer(shadow_cfg.restart_period);
            led_col = COL_OFF;
         end
         default: ;
      endcase
      return meas;
   endfunction

   function automatic cis_rsp_type predict_status(input cis_req_type item);
      cis_rsp_type s;
      int          n;
      logic        meas;
      meas = 1'b0;
      case (item.kind)
         KIND_TICK: begin
            if (tmr_period != 0) begin
               if (tmr_ticks >= tmr_period) begin
                  n = int'(evt_count) + 1;
                  tmr_ticks = '0;
                  if (n < int'(shadow_cfg.event_multiplier)) begin
                     evt_count = n[MULT_W-1:0];
                  end else begin
                     evt_count = '0;
                     meas = step_phase();
                  end
               end else begin
                  tmr_ticks = tmr_ticks + 1'b1;
               end
            end
         end
         KIND_BUTTON: begin
            mon_on = ~mon_on;
            if (mon_on) begin
               load_timer(shadow_cfg.short_period);
            end else begin
               load_timer('0);
               phase_cur = PHC_MEASURE;
               led_col = COL_OFF;
            end
         end
         KIND_MEASURE: begin
            level_cur = classify_climate(int'($signed(item.temperature)), int'(item.humidity));
            phase_cur = PHC_LED_OFF;
         end
         default: ;
      endcase
      s.led_color       = led_col;
      s.measure_request = meas;
      s.comfort_class   = level_cur;
      s.monitoring_on   = mon_on;
      s.phase_now       = phase_cur;
      return s;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
      end else begin
         if (req_valid && req_ready) begin
            status_expect.push_back(predict_status(req_data));
            reqs_taken <= reqs_taken + 1;
         end
         if (!req_valid || req_ready) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= req_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
         mismatches++;
      end
   endtask

   // response monitor
   always @(posedge clock) begin : monitor
      cis_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (status_expect.size() == 0) begin
               $display("%0t: unexpected response, expected none actual %h", $time, rsp_data);
               mismatches++;
            end else begin
               want = status_expect.pop_front();
               check_field("led_color", want.led_color, rsp_data.led_color);
               check_field("measure_request", want.measure_request, rsp_data.measure_request);
               check_field("comfort_class", want.comfort_class, rsp_data.comfort_class);
               check_field("monitoring_on", want.monitoring_on, rsp_data.monitoring_on);
               check_field("phase_now", want.phase_now, rsp_data.phase_now);
            end
         end
         rsp_ready <= (stall_left != 0) ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // one long receiver hold-off so the block backs up into the request side
   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
      end else if (!stall_done && reqs_taken >= 300) begin
         stall_left <= 60;
         stall_done <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_EVENT_MULT:  shadow_cfg.event_multiplier = value[MULT_W-1:0];
         REG_BLINK_LIMIT: shadow_cfg.blink_limit = value[BLINK_W-1:0];
         REG_LONG:        shadow_cfg.long_period = value;
         REG_BLINK_ON:    shadow_cfg.blink_on_period = value;
         REG_BLINK_OFF:   shadow_cfg.blink_off_period = value;
         REG_SHORT:       shadow_cfg.short_period = value;
         REG_RESTART:     shadow_cfg.restart_period = value;
         REG_DRY_THRESH:  shadow_cfg.dry_threshold = value[HUM_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_setting(input int ph);
      logic [MULT_W-1:0]   m;
      logic [BLINK_W-1:0]  bl;
      logic [PERIOD_W-1:0] lp, on_p, off_p, sp, rp;
      logic [HUM_W-1:0]    dry;
      case (ph)
         0: begin
            m = 1; bl = 3; lp = 2; on_p = 1; off_p = 1; sp = 1; rp = 1; dry = 50;
         end
         1: begin
            // zero multiplier: every timer event steps the phase
            m = 0; bl = 15; lp = 1; on_p = 2; off_p = 3; sp = 2; rp = 3; dry = 0;
         end
         2: begin
            m = 255; bl = 0; lp = 16'hFFFF; on_p = 16'hFFFF; off_p = 16'hFFFF;
            sp = 1; rp = 16'hFFFF; dry = 100;
         end
         3: begin
            // event count left high by the previous setting steps at the next event
            m = 2; bl = 1; lp = 3; on_p = 1; off_p = 2; sp = 1; rp = 2; dry = 75;
         end
         default: begin
            m = MULT_W'($urandom_range(3));
            bl = BLINK_W'($urandom_range(15));
            lp = PERIOD_W'($urandom_range(4, 1));
            on_p = PERIOD_W'($urandom_range(3, 1));
            off_p = PERIOD_W'($urandom_range(3, 1));
            sp = PERIOD_W'($urandom_range(2, 1));
            rp = PERIOD_W'($urandom_range(3, 1));
            dry = HUM_W'($urandom_range(100));
         end
      endcase
      // unused upper data bits carry noise
      write_reg(REG_EVENT_MULT, {8'($urandom), m});
      write_reg(REG_BLINK_LIMIT, {12'($urandom), bl});
      write_reg(REG_LONG, lp);
      write_reg(REG_BLINK_ON, on_p);
      write_reg(REG_BLINK_OFF, off_p);
      write_reg(REG_SHORT, sp);
      write_reg(REG_RESTART, rp);
      write_reg(REG_DRY_THRESH, {9'($urandom), dry});
   endtask

   task automatic add_item(input logic [KIND_W-1:0] kind, input int t, input int h);
      cis_req_type it;
      it.kind = kind;
      it.temperature = t[TEMP_W-1:0];
      it.humidity = h[HUM_W-1:0];
      req_backlog.push_back(it);
      if (kind == KIND_BUTTON) gen_on = ~gen_on;
   endtask

   task automatic directed_items();
      add_item(KIND_UNUSED, -128, 127);
      add_item(KIND_TICK, 0, 0);            // timer stopped
      add_item(KIND_MEASURE, -128, 0);      // measurement while monitoring is off
      add_item(KIND_MEASURE, 127, 127);
      add_item(KIND_MEASURE, 21, 50);
      add_item(KIND_MEASURE, 16, 75);
      add_item(KIND_MEASURE, 27, 32);
      add_item(KIND_MEASURE, -40, 100);
      add_item(KIND_MEASURE, 80, 0);
      add_item(KIND_BUTTON, 0, 0);
      repeat (6) add_item(KIND_TICK, 0, 0);
      add_item(KIND_MEASURE, 18, 63);
      repeat (4) add_item(KIND_TICK, 0, 0);
      add_item(KIND_BUTTON, 0, 0);          // off: event and blink counts keep their values
      add_item(KIND_TICK, 0, 0);
      add_item(KIND_BUTTON, 0, 0);
      add_item(KIND_MEASURE, 24, 41);
   endtask

   task automatic random_items(input int count);
      int               k, r, sel, t, h;
      logic [KIND_W-1:0] kind;
      for (k = 0; k < count; k++) begin
         r = $urandom_range(99);
         if (!gen_on && r < 40) kind = KIND_BUTTON;
         else if (r < 2) kind = KIND_BUTTON;
         else if (r < 4) kind = KIND_UNUSED;
         else if (r < 11) kind = KIND_MEASURE;
         else kind = KIND_TICK;
         sel = $urandom_range(9);
         if (sel < 5) begin
            t = $urandom_range(29, 14);
            h = $urandom_range(95, 10);
         end else if (sel < 8) begin
            t = $urandom_range(120) - 40;
            h = $urandom_range(100);
         end else begin
            t = $urandom_range(255);
            h = $urandom_range(127);
         end
         add_item(kind, t, h);
      end
   endtask

   task automatic wait_drained();
      while (req_backlog.size() != 0 || status_expect.size() != 0 || req_valid)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      int ph;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (ph = 0; ph < 6; ph++) begin
         wait_drained();
         send_idle_pct <= (ph < 2) ? 11 : (ph < 4) ? 82 : 0;
         recv_idle_pct <= (ph < 2) ? 82 : (ph < 4) ? 11 : 0;
         program_setting(ph);
         repeat (2) @(posedge clock);
         @(negedge clock);
         if (ph == 0) directed_items();
         random_items((ph == 0) ? 205 : 235);
      end
      wait_drained();
      repeat (4) @(posedge clock);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #3000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

[comfort_indicator_sequencer.f]
+incdir+src
src/cis_pkg.sv
src/cis_classify.sv
src/cis_csr.sv
src/cis_core.sv
src/comfort_indicator_sequencer.sv
bench/tb_top.sv
